### rtl/mcl_pkg.sv
// Shared types and constants of the mesh connected component labeler.
`timescale 1ns / 1ps
package mcl_pkg;

  // Default sizes of the vertex table and the triangle store.
  localparam int MaxVertices  = 1024;
  localparam int MaxTriangles = 2048;

  // Fixed widths of the item fields.
  localparam int VtxW    = 10;
  localparam int ActW    = 3;
  localparam int AnsW    = 11;
  localparam int CompW   = 10;
  localparam int StatW   = 2;
  localparam int TriW    = 3 * VtxW;
  localparam int InDataW = 40;
  localparam int OutDataW = 16;

  // Item actions.
  typedef enum logic [ActW-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_RUN    = 3'd3,
    ACT_QUERY  = 3'd4
  } act_e;

  // Result status codes.
  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd2;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_QRD,
    ST_PINIT,
    ST_TNEXT,
    ST_TWAIT,
    ST_RA,
    ST_RB,
    ST_RC,
    ST_FA0,
    ST_FA,
    ST_FB,
    ST_VSTART,
    ST_VRD,
    ST_VFIND,
    ST_VCOMP,
    ST_RUNEND,
    ST_DONE
  } state_e;

  // Field write enables of one vertex table word.
  typedef struct packed {
    logic removed;
    logic parent;
    logic comp;
  } vtx_we_t;

endpackage

### rtl/mcl_tri_store.sv
// Triangle store: one write port, one registered read port.
`timescale 1ns / 1ps
module mcl_tri_store #(
  parameter int Depth = mcl_pkg::MaxTriangles,
  parameter int AW    = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [mcl_pkg::TriW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [mcl_pkg::TriW-1:0] rdata_o
);

  logic [mcl_pkg::TriW-1:0] mem_q [Depth];
  logic [mcl_pkg::TriW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mcl_vtx_table.sv
// Vertex table: removed flag, parent link and component number per vertex.
`timescale 1ns / 1ps
module mcl_vtx_table #(
  parameter int Depth = mcl_pkg::MaxVertices,
  parameter int AW    = 10
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  mcl_pkg::vtx_we_t          we_i,
  input  logic [AW-1:0]             addr_i,
  input  logic                      wremoved_i,
  input  logic [AW-1:0]             wparent_i,
  input  logic [mcl_pkg::CompW-1:0] wcomp_i,
  output logic                      rremoved_o,
  output logic [AW-1:0]             rparent_o,
  output logic [mcl_pkg::CompW-1:0] rcomp_o
);

  localparam int WordW = 1 + AW + mcl_pkg::CompW;

  logic [WordW-1:0] mem_q [Depth];
  logic [WordW-1:0] rdata_q;

  // Single port; each field has its own write enable.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i.removed) begin
        mem_q[addr_i][0] <= wremoved_i;
      end
      if (we_i.parent) begin
        mem_q[addr_i][AW:1] <= wparent_i;
      end
      if (we_i.comp) begin
        mem_q[addr_i][WordW-1:AW+1] <= wcomp_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rremoved_o = rdata_q[0];
  assign rparent_o  = rdata_q[AW:1];
  assign rcomp_o    = rdata_q[WordW-1:AW+1];

endmodule

### rtl/mcl_ctrl.sv
// Sequencer: item decode, union-find labeling run and output register.
`timescale 1ns / 1ps
module mcl_ctrl #(
  parameter int MaxVertices  = mcl_pkg::MaxVertices,
  parameter int MaxTriangles = mcl_pkg::MaxTriangles,
  parameter int VW           = 10,
  parameter int TW           = 11,
  parameter int VCW          = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [VCW-1:0]               vcount_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mcl_pkg::InDataW-1:0]  in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mcl_pkg::OutDataW-1:0] out_data_o,
  output logic                         tri_we_o,
  output logic [TW-1:0]                tri_waddr_o,
  output logic [mcl_pkg::TriW-1:0]     tri_wdata_o,
  output logic                         tri_re_o,
  output logic [TW-1:0]                tri_raddr_o,
  input  logic [mcl_pkg::TriW-1:0]     tri_rdata_i,
  output logic                         vtx_en_o,
  output mcl_pkg::vtx_we_t             vtx_we_o,
  output logic [VW-1:0]                vtx_addr_o,
  output logic                         vtx_wremoved_o,
  output logic [VW-1:0]                vtx_wparent_o,
  output logic [mcl_pkg::CompW-1:0]    vtx_wcomp_o,
  input  logic                         vtx_rremoved_i,
  input  logic [VW-1:0]                vtx_rparent_i,
  input  logic [mcl_pkg::CompW-1:0]    vtx_rcomp_i
);

  localparam int FW   = $clog2(MaxTriangles + 1);
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam logic [VW-1:0] LastVtx = VW'(MaxVertices - 1);
  localparam logic [FW-1:0] FullFill = FW'(MaxTriangles);

  mcl_pkg::state_e state_q, state_d;
  logic [mcl_pkg::VtxW-1:0]  a_q, a_d, b_q, b_d, c_q, c_d;
  logic [VW-1:0]             idx_q, idx_d, cur_q, cur_d, ra_q, ra_d, oth_q, oth_d;
  logic                      jp_q, jp_d, clr_reply_q, clr_reply_d;
  logic [FW-1:0]             t_q, t_d, fill_q, fill_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [mcl_pkg::AnsW-1:0]  res_ans_q, res_ans_d;
  logic                      res_rm_q, res_rm_d;
  logic [mcl_pkg::StatW-1:0] res_st_q, res_st_d;
  logic                      out_valid_q, out_valid_d;
  logic [mcl_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                      in_fire, out_load, v_adv;
  logic [mcl_pkg::VtxW-1:0]  in_a, in_b, in_c, tr_a, tr_b, tr_c;
  logic                      in_a_bad, in_tri_bad, tr_bad;

  // Field unpacking of the input beat and of a stored triangle.
  assign in_a = in_data_i[12:3];
  assign in_b = in_data_i[22:13];
  assign in_c = in_data_i[32:23];
  assign tr_a = tri_rdata_i[9:0];
  assign tr_b = tri_rdata_i[19:10];
  assign tr_c = tri_rdata_i[29:20];

  assign in_a_bad   = VCW'(in_a) >= vcount_i;
  assign in_tri_bad = in_a_bad || (VCW'(in_b) >= vcount_i) || (VCW'(in_c) >= vcount_i);
  assign tr_bad     = (VCW'(tr_a) >= vcount_i) || (VCW'(tr_b) >= vcount_i) ||
                      (VCW'(tr_c) >= vcount_i);

  assign in_ready_o = (state_q == mcl_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // State and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcl_pkg::ST_CLR;
      idx_q       <= '0;
      clr_reply_q <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      clr_reply_q <= clr_reply_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    c_q        <= c_d;
    cur_q      <= cur_d;
    ra_q       <= ra_d;
    oth_q      <= oth_d;
    jp_q       <= jp_d;
    t_q        <= t_d;
    cnt_q      <= cnt_d;
    res_ans_q  <= res_ans_d;
    res_rm_q   <= res_rm_d;
    res_st_q   <= res_st_d;
    out_data_q <= out_data_d;
  end

  // Next state, memory accesses and results.
  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    ra_d        = ra_q;
    oth_d       = oth_q;
    jp_d        = jp_q;
    clr_reply_d = clr_reply_q;
    t_d         = t_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    res_ans_d   = res_ans_q;
    res_rm_d    = res_rm_q;
    res_st_d    = res_st_q;
    out_load    = 1'b0;
    v_adv       = 1'b0;

    tri_we_o       = 1'b0;
    tri_waddr_o    = TW'(fill_q);
    tri_wdata_o    = {in_c, in_b, in_a};
    tri_re_o       = 1'b0;
    tri_raddr_o    = TW'(t_q);
    vtx_en_o       = 1'b0;
    vtx_we_o       = '0;
    vtx_addr_o     = idx_q;
    vtx_wremoved_o = 1'b0;
    vtx_wparent_o  = idx_q;
    vtx_wcomp_o    = '0;

    unique case (state_q)
      mcl_pkg::ST_IDLE: begin
        if (in_fire) begin
          a_d       = in_a;
          b_d       = in_b;
          c_d       = in_c;
          res_ans_d = '0;
          res_rm_d  = 1'b0;
          res_st_d  = mcl_pkg::STAT_OK;
          state_d   = mcl_pkg::ST_DONE;
          unique case (mcl_pkg::act_e'(in_data_i[2:0]))
            mcl_pkg::ACT_CLEAR: begin
              fill_d      = '0;
              idx_d       = '0;
              clr_reply_d = 1'b1;
              state_d     = mcl_pkg::ST_CLR;
            end
            mcl_pkg::ACT_ADD: begin
              if (in_tri_bad) begin
                res_st_d = mcl_pkg::STAT_RANGE;
              end else if (fill_q == FullFill) begin
                res_st_d = mcl_pkg::STAT_FULL;
              end else begin
                tri_we_o = 1'b1;
                fill_d   = fill_q + 1'b1;
              end
            end
            mcl_pkg::ACT_REMOVE: begin
              if (in_a_bad) begin
                res_st_d = mcl_pkg::STAT_RANGE;
              end else begin
                vtx_en_o         = 1'b1;
                vtx_we_o.removed = 1'b1;
                vtx_addr_o       = VW'(in_a);
                vtx_wremoved_o   = 1'b1;
              end
            end
            mcl_pkg::ACT_RUN: begin
              idx_d   = '0;
              state_d = mcl_pkg::ST_PINIT;
            end
            mcl_pkg::ACT_QUERY: begin
              if (in_a_bad) begin
                res_st_d = mcl_pkg::STAT_RANGE;
              end else begin
                vtx_en_o   = 1'b1;
                vtx_addr_o = VW'(in_a);
                state_d    = mcl_pkg::ST_QRD;
              end
            end
            default: begin
              state_d = mcl_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Sweep that clears every removed flag.
      mcl_pkg::ST_CLR: begin
        vtx_en_o         = 1'b1;
        vtx_we_o.removed = 1'b1;
        if (idx_q == LastVtx) begin
          state_d     = clr_reply_q ? mcl_pkg::ST_DONE : mcl_pkg::ST_IDLE;
          clr_reply_d = 1'b0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      mcl_pkg::ST_QRD: begin
        if (vtx_rremoved_i) begin
          res_rm_d = 1'b1;
        end else begin
          res_ans_d = mcl_pkg::AnsW'(vtx_rcomp_i);
        end
        state_d = mcl_pkg::ST_DONE;
      end

      // Every vertex starts as its own root.
      mcl_pkg::ST_PINIT: begin
        vtx_en_o        = 1'b1;
        vtx_we_o.parent = 1'b1;
        if (idx_q == LastVtx) begin
          t_d     = '0;
          state_d = mcl_pkg::ST_TNEXT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      mcl_pkg::ST_TNEXT: begin
        if (t_q == fill_q) begin
          idx_d   = '0;
          cnt_d   = '0;
          state_d = mcl_pkg::ST_VSTART;
        end else begin
          tri_re_o = 1'b1;
          state_d  = mcl_pkg::ST_TWAIT;
        end
      end

      // Triangle word arrives; stale corners skip it.
      mcl_pkg::ST_TWAIT: begin
        a_d = tr_a;
        b_d = tr_b;
        c_d = tr_c;
        if (tr_bad) begin
          t_d     = t_q + 1'b1;
          state_d = mcl_pkg::ST_TNEXT;
        end else begin
          vtx_en_o   = 1'b1;
          vtx_addr_o = VW'(tr_a);
          state_d    = mcl_pkg::ST_RA;
        end
      end

      mcl_pkg::ST_RA: begin
        if (vtx_rremoved_i) begin
          t_d     = t_q + 1'b1;
          state_d = mcl_pkg::ST_TNEXT;
        end else begin
          vtx_en_o   = 1'b1;
          vtx_addr_o = VW'(b_q);
          state_d    = mcl_pkg::ST_RB;
        end
      end

      mcl_pkg::ST_RB: begin
        if (vtx_rremoved_i) begin
          t_d     = t_q + 1'b1;
          state_d = mcl_pkg::ST_TNEXT;
        end else begin
          vtx_en_o   = 1'b1;
          vtx_addr_o = VW'(c_q);
          state_d    = mcl_pkg::ST_RC;
        end
      end

      mcl_pkg::ST_RC: begin
        if (vtx_rremoved_i) begin
          t_d     = t_q + 1'b1;
          state_d = mcl_pkg::ST_TNEXT;
        end else begin
          jp_d    = 1'b0;
          oth_d   = VW'(b_q);
          state_d = mcl_pkg::ST_FA0;
        end
      end

      mcl_pkg::ST_FA0: begin
        vtx_en_o   = 1'b1;
        vtx_addr_o = VW'(a_q);
        cur_d      = VW'(a_q);
        state_d    = mcl_pkg::ST_FA;
      end

      // Walk parent links up to the root of the first corner.
      mcl_pkg::ST_FA: begin
        vtx_en_o = 1'b1;
        if (vtx_rparent_i == cur_q) begin
          ra_d       = cur_q;
          cur_d      = oth_q;
          vtx_addr_o = oth_q;
          state_d    = mcl_pkg::ST_FB;
        end else begin
          cur_d      = vtx_rparent_i;
          vtx_addr_o = vtx_rparent_i;
        end
      end

      // Root of the other corner; the larger root links to the smaller.
      mcl_pkg::ST_FB: begin
        if (vtx_rparent_i == cur_q) begin
          if (ra_q < cur_q) begin
            vtx_en_o        = 1'b1;
            vtx_we_o.parent = 1'b1;
            vtx_addr_o      = cur_q;
            vtx_wparent_o   = ra_q;
          end else if (cur_q < ra_q) begin
            vtx_en_o        = 1'b1;
            vtx_we_o.parent = 1'b1;
            vtx_addr_o      = ra_q;
            vtx_wparent_o   = cur_q;
          end
          if (!jp_q) begin
            jp_d    = 1'b1;
            oth_d   = VW'(c_q);
            state_d = mcl_pkg::ST_FA0;
          end else begin
            t_d     = t_q + 1'b1;
            state_d = mcl_pkg::ST_TNEXT;
          end
        end else begin
          vtx_en_o   = 1'b1;
          cur_d      = vtx_rparent_i;
          vtx_addr_o = vtx_rparent_i;
        end
      end

      // Numbering pass over all vertex entries.
      mcl_pkg::ST_VSTART: begin
        vtx_en_o = 1'b1;
        if (VCW'(idx_q) >= vcount_i) begin
          vtx_we_o.comp = 1'b1;
          v_adv         = 1'b1;
        end else begin
          state_d = mcl_pkg::ST_VRD;
        end
      end

      mcl_pkg::ST_VRD: begin
        vtx_en_o = 1'b1;
        if (vtx_rremoved_i) begin
          vtx_we_o.comp = 1'b1;
          v_adv         = 1'b1;
        end else if (vtx_rparent_i == idx_q) begin
          vtx_we_o.comp = 1'b1;
          vtx_wcomp_o   = mcl_pkg::CompW'(cnt_q);
          cnt_d         = cnt_q + 1'b1;
          v_adv         = 1'b1;
        end else begin
          cur_d      = vtx_rparent_i;
          vtx_addr_o = vtx_rparent_i;
          state_d    = mcl_pkg::ST_VFIND;
        end
      end

      mcl_pkg::ST_VFIND: begin
        vtx_en_o = 1'b1;
        if (vtx_rparent_i == cur_q) begin
          vtx_addr_o = cur_q;
          state_d    = mcl_pkg::ST_VCOMP;
        end else begin
          cur_d      = vtx_rparent_i;
          vtx_addr_o = vtx_rparent_i;
        end
      end

      // Copy the number already given to the root.
      mcl_pkg::ST_VCOMP: begin
        vtx_en_o      = 1'b1;
        vtx_we_o.comp = 1'b1;
        vtx_wcomp_o   = vtx_rcomp_i;
        v_adv         = 1'b1;
      end

      mcl_pkg::ST_RUNEND: begin
        res_ans_d = mcl_pkg::AnsW'(cnt_q);
        state_d   = mcl_pkg::ST_DONE;
      end

      mcl_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = mcl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mcl_pkg::ST_IDLE;
      end
    endcase

    // Step to the next vertex of the numbering pass.
    if (v_adv) begin
      if (idx_q == LastVtx) begin
        state_d = mcl_pkg::ST_RUNEND;
      end else begin
        idx_d   = idx_q + 1'b1;
        state_d = mcl_pkg::ST_VSTART;
      end
    end
  end

  // Output register: holds one result beat until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {2'b00, res_st_q, res_rm_q, res_ans_q};
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks on the sequencer.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill)
    else $error("triangle fill count beyond capacity");

  a_link_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcl_pkg::ST_FB && vtx_we_o.parent) |-> (vtx_wparent_o < vtx_addr_o))
    else $error("root linked to a larger root");

  a_done_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcl_pkg::ST_DONE && (!out_valid_q || out_ready_i)) |=>
    (state_q == mcl_pkg::ST_IDLE && out_valid_q))
    else $error("result not handed to the output register");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcl_pkg::ST_RUNEND) |-> (cnt_q <= CntW'(MaxVertices)))
    else $error("component count beyond vertex capacity");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcl_pkg::ST_CLR) |-> !in_ready_o)
    else $error("item accepted during clearing sweep");

endmodule

### rtl/mesh_connected_component_labeler.sv
// Top level of the mesh connected component labeler.
//
// Input stream s_axis carries one command beat per item (clear, add triangle,
// remove vertex, run labeling, query vertex); output stream m_axis returns
// exactly one result beat per item. The cfg channel writes vertex_count,
// saturated to MAX_VERTICES, and is always ready.
// Clear sweeps the removed flags, one vertex table entry a cycle. A labeling
// run uses the single vertex table port: it resets the parent links, then
// walks the parent links of each triangle's corners to join their roots,
// then numbers each vertex after a walk to its root.
// After reset the same clearing sweep runs, and no item is accepted until
// it ends; config writes are taken throughout.
// A result waits in an output register when m_axis stalls; the next item is
// accepted meanwhile, and its result waits in the sequencer until the
// register frees up.
`timescale 1ns / 1ps
module mesh_connected_component_labeler #(
  parameter int MAX_VERTICES  = mcl_pkg::MaxVertices,
  parameter int MAX_TRIANGLES = mcl_pkg::MaxTriangles
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,       // vertex_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // action, vertex_a, vertex_b, vertex_c
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // answer, vertex_removed, status
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int TW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CW0  = $clog2(MAX_VERTICES + 1);
  localparam int VCW  = (CW0 > 11) ? CW0 : 11;

  logic [VCW-1:0]               vcount_q, vcount_d;
  logic                         tri_we, tri_re;
  logic [TW-1:0]                tri_waddr, tri_raddr;
  logic [mcl_pkg::TriW-1:0]     tri_wdata, tri_rdata;
  logic                         vtx_en, vtx_wremoved, vtx_rremoved;
  mcl_pkg::vtx_we_t             vtx_we;
  logic [VW-1:0]                vtx_addr, vtx_wparent, vtx_rparent;
  logic [mcl_pkg::CompW-1:0]    vtx_wcomp, vtx_rcomp;

  // Vertex count register with saturation.
  assign cfg_ready = 1'b1;

  always_comb begin
    vcount_d = vcount_q;
    if (cfg_valid && cfg_ready) begin
      if (VCW'(cfg_data) > VCW'(MAX_VERTICES)) begin
        vcount_d = VCW'(MAX_VERTICES);
      end else begin
        vcount_d = VCW'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else begin
      vcount_q <= vcount_d;
    end
  end

  mcl_ctrl #(
    .MaxVertices (MAX_VERTICES),
    .MaxTriangles(MAX_TRIANGLES),
    .VW          (VW),
    .TW          (TW),
    .VCW         (VCW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vcount_i      (vcount_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .tri_we_o      (tri_we),
    .tri_waddr_o   (tri_waddr),
    .tri_wdata_o   (tri_wdata),
    .tri_re_o      (tri_re),
    .tri_raddr_o   (tri_raddr),
    .tri_rdata_i   (tri_rdata),
    .vtx_en_o      (vtx_en),
    .vtx_we_o      (vtx_we),
    .vtx_addr_o    (vtx_addr),
    .vtx_wremoved_o(vtx_wremoved),
    .vtx_wparent_o (vtx_wparent),
    .vtx_wcomp_o   (vtx_wcomp),
    .vtx_rremoved_i(vtx_rremoved),
    .vtx_rparent_i (vtx_rparent),
    .vtx_rcomp_i   (vtx_rcomp)
  );

  mcl_tri_store #(
    .Depth(MAX_TRIANGLES),
    .AW   (TW)
  ) u_tri_store (
    .clk_i  (clk_i),
    .we_i   (tri_we),
    .waddr_i(tri_waddr),
    .wdata_i(tri_wdata),
    .re_i   (tri_re),
    .raddr_i(tri_raddr),
    .rdata_o(tri_rdata)
  );

  mcl_vtx_table #(
    .Depth(MAX_VERTICES),
    .AW   (VW)
  ) u_vtx_table (
    .clk_i     (clk_i),
    .en_i      (vtx_en),
    .we_i      (vtx_we),
    .addr_i    (vtx_addr),
    .wremoved_i(vtx_wremoved),
    .wparent_i (vtx_wparent),
    .wcomp_i   (vtx_wcomp),
    .rremoved_o(vtx_rremoved),
    .rparent_o (vtx_rparent),
    .rcomp_o   (vtx_rcomp)
  );

endmodule

### dv/mesh_connected_component_labeler_test.sv
// Self-checking testbench of the mesh connected component labeler.
`timescale 1ns / 1ps
module mesh_connected_component_labeler_test;

  localparam int WatchLimit = 200000;
  localparam logic [mcl_pkg::ActW-1:0] ActSpare5 = 3'd5;
  localparam logic [mcl_pkg::ActW-1:0] ActSpare6 = 3'd6;
  localparam logic [mcl_pkg::ActW-1:0] ActSpare7 = 3'd7;

  typedef struct packed {
    logic [mcl_pkg::AnsW-1:0]  answer;
    logic                      removed;
    logic [mcl_pkg::StatW-1:0] status;
  } label_res_t;

  typedef struct {
    bit                        is_cfg;
    logic [10:0]               cfg_val;
    logic [mcl_pkg::ActW-1:0]  act;
    logic [mcl_pkg::VtxW-1:0]  va, vb, vc;
    bit                        known;
    label_res_t                res;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // action, vertex_a, vertex_b, vertex_c
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // answer, vertex_removed, status

  mesh_connected_component_labeler i_dut (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the mesh state.
  logic [mcl_pkg::TriW-1:0]  mesh_tris [mcl_pkg::MaxTriangles];
  int                        mesh_fill;
  bit                        gone [mcl_pkg::MaxVertices];
  int                        uplink [mcl_pkg::MaxVertices];
  logic [mcl_pkg::CompW-1:0] comp_of [mcl_pkg::MaxVertices];
  int                        live_count;
  bit                        labeled;

  label_res_t pending_results [$];
  int  errors = 0;
  int  items_sent = 0, results_seen = 0, runs_seen = 0;
  bit  calm = 1'b0;
  int  idle_cycles = 0;

  function automatic int find_root(int v);
    while (uplink[v] != v) begin
      uplink[v] = uplink[uplink[v]];
      v = uplink[v];
    end
    return v;
  endfunction

  function automatic void merge_sets(int x, int y);
    int rx, ry;
    rx = find_root(x);
    ry = find_root(y);
    if (rx < ry) uplink[ry] = rx;
    else if (ry < rx) uplink[rx] = ry;
  endfunction

  // Union of all live triangles, then numbering by smallest vertex.
  function automatic int label_mesh();
    int n, r, a, b, c;
    n = 0;
    for (int i = 0; i < mcl_pkg::MaxVertices; i++) uplink[i] = i;
    for (int i = 0; i < mesh_fill; i++) begin
      a = int'(mesh_tris[i][9:0]);
      b = int'(mesh_tris[i][19:10]);
      c = int'(mesh_tris[i][29:20]);
      if (a >= live_count || b >= live_count || c >= live_count) continue;
      if (gone[a] || gone[b] || gone[c]) continue;
      merge_sets(a, b);
      merge_sets(a, c);
    end
    for (int i = 0; i < mcl_pkg::MaxVertices; i++) begin
      if (i >= live_count || gone[i]) begin
        comp_of[i] = '0;
        continue;
      end
      r = find_root(i);
      if (r == i) begin
        comp_of[i] = n[mcl_pkg::CompW-1:0];
        n++;
      end else begin
        comp_of[i] = comp_of[r];
      end
    end
    return n;
  endfunction

  function automatic label_res_t predict_cmd(logic [mcl_pkg::ActW-1:0] act,
                                             int a, int b, int c);
    label_res_t r;
    r = '0;
    case (act)
      mcl_pkg::ACT_CLEAR: begin
        mesh_fill = 0;
        for (int i = 0; i < mcl_pkg::MaxVertices; i++) gone[i] = 1'b0;
      end
      mcl_pkg::ACT_ADD: begin
        if (a >= live_count || b >= live_count || c >= live_count)
          r.status = mcl_pkg::STAT_RANGE;
        else if (mesh_fill >= mcl_pkg::MaxTriangles) r.status = mcl_pkg::STAT_FULL;
        else begin
          mesh_tris[mesh_fill] = {c[9:0], b[9:0], a[9:0]};
          mesh_fill++;
        end
      end
      mcl_pkg::ACT_REMOVE: begin
        if (a >= live_count) r.status = mcl_pkg::STAT_RANGE;
        else gone[a] = 1'b1;
      end
      mcl_pkg::ACT_RUN: begin
        r.answer = mcl_pkg::AnsW'(label_mesh());
        labeled = 1'b1;
      end
      mcl_pkg::ACT_QUERY: begin
        if (a >= live_count) r.status = mcl_pkg::STAT_RANGE;
        else if (gone[a]) r.removed = 1'b1;
        else r.answer = mcl_pkg::AnsW'(comp_of[a]);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Output side: random back pressure, sampled beat checking.
  always @(negedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 24);

  always @(posedge clk_i) begin
    label_res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.answer  = m_axis_tdata[10:0];
      got.removed = m_axis_tdata[11];
      got.status  = m_axis_tdata[13:12];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.answer !== want.answer) begin
          $error("answer: expected %0d, got %0d", want.answer, got.answer); errors++;
        end
        if (got.removed !== want.removed) begin
          $error("vertex_removed: expected %0d, got %0d", want.removed, got.removed); errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("mesh_connected_component_labeler test failed");
      $finish;
    end
  end

  // Drive one command beat; the expectation is taken on acceptance.
  task automatic send_cmd(logic [mcl_pkg::ActW-1:0] act, int a, int b, int c,
                          bit known = 0, label_res_t res = '0);
    label_res_t p;
    while (!calm && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, c[9:0], b[9:0], a[9:0], act};
    do @(posedge clk_i); while (!s_axis_tready);
    p = predict_cmd(act, a, b, c);
    pending_results = {pending_results, (known ? res : p)};
    items_sent++;
    if (act == mcl_pkg::ACT_RUN) runs_seen++;
    @(negedge clk_i);
  endtask

  // Write vertex_count once every result is back.
  task automatic write_count(logic [10:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    live_count = (v > mcl_pkg::MaxVertices) ? mcl_pkg::MaxVertices : v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  cmd_row_t rows [$];

  function automatic void add_row(cmd_row_t r);
    rows = {rows, r};
  endfunction

  function automatic cmd_row_t mk(logic [mcl_pkg::ActW-1:0] act, int a, int b, int c,
                                  bit known = 0, label_res_t res = '0);
    cmd_row_t r;
    r = '{default: '0};
    r.act = act;
    r.va = mcl_pkg::VtxW'(a); r.vb = mcl_pkg::VtxW'(b); r.vc = mcl_pkg::VtxW'(c);
    r.known = known; r.res = res;
    return r;
  endfunction

  function automatic cmd_row_t mkcfg(logic [10:0] v);
    cmd_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1; r.cfg_val = v;
    return r;
  endfunction

  initial begin
    int vsz, a, b, c, pick;
    logic [mcl_pkg::ActW-1:0] act;
    logic [10:0] sizes [6] = '{11'd1, 11'd5, 11'd16, 11'd40, 11'd300, 11'd1024};

    mesh_fill = 0; live_count = 0; labeled = 1'b0;
    for (int i = 0; i < mcl_pkg::MaxVertices; i++) begin
      gone[i] = 1'b0; uplink[i] = i; comp_of[i] = '0;
    end

    // Directed rows: empty mesh, widest mesh, removal and clear cases.
    add_row(mk(mcl_pkg::ACT_ADD, 0, 0, 0, 1, '{0, 0, mcl_pkg::STAT_RANGE}));
    add_row(mk(mcl_pkg::ACT_REMOVE, 0, 0, 0, 1, '{0, 0, mcl_pkg::STAT_RANGE}));
    add_row(mk(mcl_pkg::ACT_QUERY, 1023, 0, 0, 1, '{0, 0, mcl_pkg::STAT_RANGE}));
    add_row(mk(mcl_pkg::ACT_RUN, 0, 0, 0, 1, '{0, 0, mcl_pkg::STAT_OK}));
    add_row(mk(ActSpare7, 1023, 1023, 1023, 1, '{0, 0, mcl_pkg::STAT_OK}));
    add_row(mkcfg(11'd1024));
    add_row(mk(mcl_pkg::ACT_ADD, 0, 1, 2, 1, '{0, 0, mcl_pkg::STAT_OK}));
    add_row(mk(mcl_pkg::ACT_ADD, 1023, 1022, 1021, 1, '{0, 0, mcl_pkg::STAT_OK}));
    add_row(mk(mcl_pkg::ACT_ADD, 3, 4, 5));
    add_row(mk(mcl_pkg::ACT_REMOVE, 4, 0, 0, 1, '{0, 0, mcl_pkg::STAT_OK}));
    add_row(mk(mcl_pkg::ACT_RUN, 0, 0, 0));
    add_row(mk(mcl_pkg::ACT_QUERY, 0, 0, 0, 1, '{0, 0, mcl_pkg::STAT_OK}));
    add_row(mk(mcl_pkg::ACT_QUERY, 4, 0, 0, 1, '{0, 1, mcl_pkg::STAT_OK}));
    add_row(mk(mcl_pkg::ACT_QUERY, 1023, 0, 0));
    add_row(mk(mcl_pkg::ACT_REMOVE, 1023, 0, 0));
    add_row(mk(mcl_pkg::ACT_QUERY, 1023, 0, 0, 1, '{0, 1, mcl_pkg::STAT_OK}));
    add_row(mk(ActSpare5, 7, 8, 9, 1, '{0, 0, mcl_pkg::STAT_OK}));
    add_row(mk(ActSpare6, 0, 0, 0, 1, '{0, 0, mcl_pkg::STAT_OK}));
    add_row(mk(mcl_pkg::ACT_CLEAR, 0, 0, 0, 1, '{0, 0, mcl_pkg::STAT_OK}));
    add_row(mk(mcl_pkg::ACT_QUERY, 5, 0, 0));
    add_row(mkcfg(11'd2047));
    add_row(mk(mcl_pkg::ACT_ADD, 10, 11, 1023));
    add_row(mk(mcl_pkg::ACT_RUN, 0, 0, 0));
    add_row(mkcfg(11'd3));
    add_row(mk(mcl_pkg::ACT_RUN, 0, 0, 0));
    add_row(mk(mcl_pkg::ACT_QUERY, 2, 0, 0));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_count(rows[i].cfg_val);
      else send_cmd(rows[i].act, rows[i].va, rows[i].vb, rows[i].vc,
                    rows[i].known, rows[i].res);
    end

    // Back-to-back burst of small triangles, without idling.
    calm = 1'b1;
    write_count(11'd4);
    send_cmd(mcl_pkg::ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < 60; i++)
      send_cmd(mcl_pkg::ACT_ADD, $urandom_range(3), $urandom_range(3), $urandom_range(3));
    send_cmd(mcl_pkg::ACT_ADD, 0, 1, 9);
    send_cmd(mcl_pkg::ACT_RUN, 0, 0, 0);
    send_cmd(mcl_pkg::ACT_QUERY, 3, 0, 0);
    calm = 1'b0;
    // Lowered count leaves stale triangles behind.
    write_count(11'd2);
    send_cmd(mcl_pkg::ACT_RUN, 0, 0, 0);
    send_cmd(mcl_pkg::ACT_QUERY, 1, 0, 0);

    // Random phases, one vertex count each.
    for (int ph = 0; ph < 6; ph++) begin
      vsz = sizes[$urandom_range(5)];
      if (ph == 5) vsz = 1024;
      write_count(11'(vsz + (($urandom_range(9) == 0) ? 3 : 0)));
      send_cmd(mcl_pkg::ACT_CLEAR, 0, 0, 0);
      for (int k = 0; k < 57; k++) begin
        pick = $urandom_range(99);
        a = $urandom_range(vsz - 1);
        b = ($urandom_range(3) == 0) ? a : $urandom_range(vsz - 1);
        c = $urandom_range(vsz - 1);
        if (pick < 45) send_cmd(mcl_pkg::ACT_ADD, a, b, c);
        else if (pick < 55) send_cmd(mcl_pkg::ACT_REMOVE, a, 0, 0);
        else if (pick < 63) send_cmd(mcl_pkg::ACT_RUN, 0, 0, 0);
        else if (pick < 82) begin
          if (labeled) send_cmd(mcl_pkg::ACT_QUERY, a, 0, 0);
          else send_cmd(mcl_pkg::ACT_RUN, 0, 0, 0);
        end else if (pick < 85) send_cmd(mcl_pkg::ACT_CLEAR, 0, 0, 0);
        else begin
          // Noise: any action with any field values.
          act = mcl_pkg::ActW'($urandom_range(7));
          a = $urandom_range(1023);
          if (act == mcl_pkg::ACT_QUERY && !labeled && a < live_count)
            act = mcl_pkg::ACT_RUN;
          send_cmd(act, a, $urandom_range(1023), $urandom_range(1023));
        end
      end
      send_cmd(mcl_pkg::ACT_RUN, 0, 0, 0);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Sent %0d command beats including %0d labeling runs; %0d result beats checked.",
             items_sent, runs_seen, results_seen);
    if (errors == 0 && pending_results.size() == 0)
      $display("mesh_connected_component_labeler test passed");
    else
      $display("mesh_connected_component_labeler test failed");
    $finish;
  end

endmodule
